/* rtl/core/iebm_pkg.sv */
// iebm_pkg: shared types and constants of the i2c eeprom byte master
// phase codes, transfer payload structs and sequencer state struct
// no dependencies
`default_nettype none

package iebm_pkg;

  // seven-bit slave address after reset
  localparam logic [6:0] DEV_ADDR_RST = 7'd80;
  // last bit position within a byte
  localparam logic [2:0] LAST_BIT     = 3'd7;
  // quarter positions within a bit period
  localparam logic [1:0] Q_SAMPLE     = 2'd2;
  localparam logic [1:0] Q_LAST       = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START  = 4'd1,
    PH_DEVW   = 4'd2,
    PH_ACK1   = 4'd3,
    PH_ADDR   = 4'd4,
    PH_ACK2   = 4'd5,
    PH_DATA   = 4'd6,
    PH_ACK3   = 4'd7,
    PH_RSTART = 4'd8,
    PH_DEVR   = 4'd9,
    PH_ACK4   = 4'd10,
    PH_RX     = 4'd11,
    PH_MNACK  = 4'd12,
    PH_STOP   = 4'd13
  } phase_t;

  typedef struct packed {
    logic       start_req;
    logic       mode;
    logic [7:0] word_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic       nack_seen;
    logic [7:0] rx_data;
    logic       data_match;
  } out_item_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] qcnt;
    logic [2:0] bit_idx;
    logic [7:0] tx_shift;
    logic [7:0] rx_shift;
    logic [7:0] lat_addr;
    logic [7:0] lat_data;
    logic       lat_mode;
    logic       nack;
  } seq_state_t;

endpackage : iebm_pkg

`default_nettype wire

/* rtl/core/iebm_seq.sv */
// iebm_seq: one quarter-bit step of the i2c byte sequencer, purely combinational
// gives the next sequencer state and the result item of the step
// depends on iebm_pkg
`default_nettype none

module iebm_seq (
  input  iebm_pkg::seq_state_t st,
  input  iebm_pkg::in_item_t   item,
  input  logic [6:0]           dev_addr,
  output iebm_pkg::seq_state_t st_nxt,
  output iebm_pkg::out_item_t  res
);
  import iebm_pkg::*;

  function automatic logic is_tx(input phase_t p);
    is_tx = (p inside {PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR});
  endfunction

  function automatic phase_t next_phase(input phase_t p, input logic rd);
    case (p)
      PH_IDLE:   next_phase = PH_START;
      PH_START:  next_phase = PH_DEVW;
      PH_DEVW:   next_phase = PH_ACK1;
      PH_ACK1:   next_phase = PH_ADDR;
      PH_ADDR:   next_phase = PH_ACK2;
      PH_ACK2:   next_phase = rd ? PH_RSTART : PH_DATA;
      PH_DATA:   next_phase = PH_ACK3;
      PH_ACK3:   next_phase = PH_STOP;
      PH_RSTART: next_phase = PH_DEVR;
      PH_DEVR:   next_phase = PH_ACK4;
      PH_ACK4:   next_phase = PH_RX;
      PH_RX:     next_phase = PH_MNACK;
      PH_MNACK:  next_phase = PH_STOP;
      default:   next_phase = PH_IDLE;
    endcase
  endfunction

  logic       clk_hi;
  logic       byte_ph;
  phase_t     ph_n;
  logic [7:0] dev_byte;

  assign clk_hi   = (st.qcnt == 2'd1) || (st.qcnt == Q_SAMPLE);
  assign byte_ph  = is_tx(st.phase) || (st.phase == PH_RX);
  assign ph_n     = next_phase(st.phase, st.lat_mode);
  assign dev_byte = {dev_addr, 1'b0};

  // line levels and status, from the state before the step
  always_comb begin
    res.scl      = 1'b1;
    res.sda_low  = 1'b0;
    res.busy_res = 1'b0;
    res.done_res = 1'b0;
    case (st.phase)
      PH_IDLE: begin
        res.scl = 1'b1;
      end
      PH_START, PH_RSTART: begin
        res.busy_res = 1'b1;
        res.scl      = clk_hi;
        res.sda_low  = st.qcnt[1];
      end
      PH_STOP: begin
        res.busy_res = 1'b1;
        res.scl      = (st.qcnt != 2'd0);
        res.sda_low  = ~st.qcnt[1];
        res.done_res = (st.qcnt == Q_LAST);
      end
      PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR: begin
        res.busy_res = 1'b1;
        res.scl      = clk_hi;
        res.sda_low  = ~st.tx_shift[7];
      end
      PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4, PH_RX, PH_MNACK: begin
        res.busy_res = 1'b1;
        res.scl      = clk_hi;
      end
      default: begin
        res.scl = 1'b1;
      end
    endcase
    // status fields after this step's sampling
    res.nack_seen  = st_nxt.nack;
    res.rx_data    = st_nxt.rx_shift;
    res.data_match = st_nxt.lat_mode && (st_nxt.rx_shift == st_nxt.lat_data);
  end

  // sequencer next state
  always_comb begin
    st_nxt = st;
    case (st.phase)
      PH_IDLE: begin
        if (item.start_req) begin
          st_nxt.lat_mode = item.mode;
          st_nxt.lat_addr = item.word_addr;
          st_nxt.lat_data = item.write_data;
          st_nxt.nack     = 1'b0;
          st_nxt.bit_idx  = '0;
          st_nxt.qcnt     = '0;
          st_nxt.phase    = PH_START;
        end
      end
      PH_START, PH_DEVW, PH_ACK1, PH_ADDR, PH_ACK2, PH_DATA, PH_ACK3, PH_RSTART,
      PH_DEVR, PH_ACK4, PH_RX, PH_MNACK, PH_STOP: begin
        // sample the slave while scl is high
        if (st.qcnt == Q_SAMPLE) begin
          if (st.phase == PH_RX) begin
            st_nxt.rx_shift = {st.rx_shift[6:0], item.sda_in};
          end else if ((st.phase inside {PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4})
                       && item.sda_in) begin
            st_nxt.nack = 1'b1;
          end
        end
        if (st.qcnt != Q_LAST) begin
          st_nxt.qcnt = st.qcnt + 2'd1;
        end else begin
          st_nxt.qcnt = '0;
          if (byte_ph && (st.bit_idx != LAST_BIT)) begin
            st_nxt.bit_idx = st.bit_idx + 3'd1;
            if (is_tx(st.phase)) begin
              st_nxt.tx_shift = {st.tx_shift[6:0], 1'b0};
            end
          end else begin
            st_nxt.bit_idx = '0;
            st_nxt.phase   = ph_n;
            case (ph_n)
              PH_DEVW: st_nxt.tx_shift = dev_byte;
              PH_ADDR: st_nxt.tx_shift = st.lat_addr;
              PH_DATA: st_nxt.tx_shift = st.lat_data;
              PH_DEVR: st_nxt.tx_shift = dev_byte | 8'h01;
              PH_RX:   st_nxt.rx_shift = '0;
              default: st_nxt.tx_shift = st.tx_shift;
            endcase
          end
        end
      end
      default: begin
        st_nxt.phase   = PH_IDLE;
        st_nxt.qcnt    = '0;
        st_nxt.bit_idx = '0;
      end
    endcase
  end

endmodule : iebm_seq

`default_nettype wire

/* rtl/core/i2c_eeprom_byte_master_top.sv */
// i2c_eeprom_byte_master_top: i2c master for eeprom byte write and random read
// holds the sequencer state, the address register and the result register
// depends on iebm_pkg and iebm_seq
//
// channel | dir | payload            | transfer when
// --------+-----+--------------------+------------------------
// in_     | in  | iebm_pkg::in_item_t  | in_valid & in_ready
// out_    | out | iebm_pkg::out_item_t | out_valid & out_ready
// cfg_    | in  | 7-bit slave address  | cfg_valid & cfg_ready
//
// one item per clock unless stalled: each input transfer is one quarter-bit
// tick and its step is computed in the same cycle into the result register
// in_ready is high while the result register is empty or being drained,
// so a full result stalls input only when out_ready is low
// cfg_ready is always high; the address register takes effect on the next tick
// reset (rst_n low, synchronous) sends the sequencer to idle, clears its state,
// empties the result register and loads the slave address 80
`default_nettype none

module i2c_eeprom_byte_master_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  iebm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output iebm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);
  import iebm_pkg::*;

  seq_state_t st_r, st_nxt;
  out_item_t  res_r, res_nxt;
  logic       res_vld_r;
  logic [6:0] dev_addr_r;
  logic       in_xfer;

  // result register drains or is empty: take the next tick
  assign in_ready  = ~res_vld_r | out_ready;
  assign in_xfer   = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  iebm_seq u_seq (
    .st       (st_r),
    .item     (in_data),
    .dev_addr (dev_addr_r),
    .st_nxt   (st_nxt),
    .res      (res_nxt)
  );

  // sequencer state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, default: '0};
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // slave address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr_r <= cfg_data;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (in_xfer) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

endmodule : i2c_eeprom_byte_master_top

`default_nettype wire
